### rtl/wet_pkg.sv
// Shared constants for the weighted edge table: field widths, action, status and register codes.
`default_nettype none
package wet_pkg;

   localparam int ACTION_W = 2;
   localparam int VTX_W    = 4;
   localparam int WEIGHT_W = 32;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam int COUNT_W    = 5;

   localparam int MAX_RESULTS = 16;
   localparam int K_W         = 5;

   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

   localparam logic [ACTION_W-1:0] ACT_ADD       = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_NEIGHBORS = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_LOWEST    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTED     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 1'b1;

endpackage
`default_nettype wire

### rtl/weighted_edge_table_top.sv
// Weighted edge table: valid-bit rows plus weight memory under a small sequencer.
//
//   channel   direction  handshake       payload
//   req_      in         valid / stall   action, src, dest, weight
//   rsp_      out        valid / stall   status, vertex_a, vertex_b, edge_weight, last
//   csr_      in         valid / ready   index, wdata
//
// An undirected add makes a second, mirrored weight write before the response.
// Neighbor query: scans one row bit per cycle, pausing to emit each neighbor found.
// Lowest edge: at most one weight memory read and one signed compare per cycle.
// Synchronous reset clears all edges; weights are undefined until written.
// rsp_ is a registered output; rsp_stall holds it and pauses the sequencer at emit.
`default_nettype none
module weighted_edge_table_top #(
   parameter int VERTICES = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic [wet_pkg::ACTION_W-1:0]   req_action,
   input  wire logic [wet_pkg::VTX_W-1:0]      req_src,
   input  wire logic [wet_pkg::VTX_W-1:0]      req_dest,
   input  wire logic signed [wet_pkg::WEIGHT_W-1:0] req_weight,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic [wet_pkg::STATUS_W-1:0]   rsp_status,
   output      logic [wet_pkg::VTX_W-1:0]      rsp_vertex_a,
   output      logic [wet_pkg::VTX_W-1:0]      rsp_vertex_b,
   output      logic signed [wet_pkg::WEIGHT_W-1:0] rsp_edge_weight,
   output      logic                           rsp_last,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [wet_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [wet_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wet_pkg::*;

   localparam int VW    = (VERTICES > 1) ? $clog2(VERTICES) : 1;
   localparam int NW    = $clog2(VERTICES + 1);
   localparam int DEPTH = VERTICES * VERTICES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_ADD_MIRROR, S_EMIT, S_NBR_SCAN, S_NBR_EMIT, S_MIN_SCAN, S_MIN_LAST, S_MIN_DONE
   } state_type;

   function automatic logic [AW-1:0] addr_of(input logic [VW-1:0] r, input logic [VW-1:0] c);
      return AW'(32'(r) * VERTICES + 32'(c));
   endfunction

   state_type               state_ff;
   logic                    directed_ff;
   logic [COUNT_W-1:0]      vcount_ff;
   logic [VERTICES-1:0]     present_ff [VERTICES];
   logic signed [WEIGHT_W-1:0] weight_mem_ff [DEPTH];
   logic signed [WEIGHT_W-1:0] rd_data_ff;

   logic [VW-1:0]           src_ff;
   logic [VW-1:0]           dst_ff;
   logic signed [WEIGHT_W-1:0] weight_ff;
   logic [NW-1:0]           col_ff;
   logic [NW-1:0]           row_ff;
   logic [K_W-1:0]          k_ff;

   logic                    cand_valid_ff;
   logic [VW-1:0]           cand_row_ff;
   logic [VW-1:0]           cand_col_ff;
   logic                    found_ff;
   logic [VW-1:0]           best_row_ff;
   logic [VW-1:0]           best_col_ff;
   logic signed [WEIGHT_W-1:0] best_w_ff;

   logic [STATUS_W-1:0]     res_status_ff;
   logic [VTX_W-1:0]        res_a_ff;
   logic [VTX_W-1:0]        res_b_ff;
   logic signed [WEIGHT_W-1:0] res_w_ff;

   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [VTX_W-1:0]        rsp_a_ff;
   logic [VTX_W-1:0]        rsp_b_ff;
   logic signed [WEIGHT_W-1:0] rsp_w_ff;
   logic                    rsp_last_ff;

   logic [NW-1:0]           n_in;
   logic                    src_ok_in;
   logic                    dst_ok_in;
   logic [VW-1:0]           req_src_idx;
   logic [VW-1:0]           req_dst_idx;
   logic [VW-1:0]           col_idx;
   logic [VW-1:0]           row_idx;
   logic                    slot_free;
   logic                    col_end_in;
   logic                    nbr_hit_in;
   logic                    min_hit_in;
   logic [VERTICES-1:0]     after_mask_in;
   logic                    more_in;
   logic                    best_take_in;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic signed [WEIGHT_W-1:0] wr_data;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;

   always_comb begin
      if (32'(vcount_ff) < VERTICES) begin
         n_in = NW'(vcount_ff);
      end else begin
         n_in = NW'(VERTICES);
      end
      src_ok_in   = 32'(req_src) < 32'(n_in);
      dst_ok_in   = 32'(req_dest) < 32'(n_in);
      req_src_idx = VW'(req_src);
      req_dst_idx = VW'(req_dest);
      col_idx     = col_ff[VW-1:0];
      row_idx     = row_ff[VW-1:0];
      slot_free   = !rsp_valid_ff || !rsp_stall;
      col_end_in  = col_ff >= n_in;
      nbr_hit_in  = !col_end_in && present_ff[src_ff][col_idx];
      min_hit_in  = present_ff[row_idx][col_idx];
      for (int x = 0; x < VERTICES; x++) begin
         after_mask_in[x] = (x > int'(col_ff)) && (x < int'(n_in));
      end
      more_in = (|(present_ff[src_ff] & after_mask_in)) && (32'(k_ff) + 1 < MAX_RESULTS);
      best_take_in = ((state_ff == S_MIN_SCAN) || (state_ff == S_MIN_LAST)) && cand_valid_ff
                     && (!found_ff || (rd_data_ff < best_w_ff));
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_of(req_src_idx, req_dst_idx);
      wr_data = req_weight;
      if (state_ff == S_ADD_MIRROR) begin
         wr_en   = 1'b1;
         wr_addr = addr_of(dst_ff, src_ff);
         wr_data = weight_ff;
      end else if (state_ff == S_IDLE && req_valid && req_action == ACT_ADD
                   && src_ok_in && dst_ok_in) begin
         wr_en = 1'b1;
      end
      rd_en   = 1'b0;
      rd_addr = addr_of(row_idx, col_idx);
      if (state_ff == S_NBR_SCAN) begin
         rd_en   = nbr_hit_in;
         rd_addr = addr_of(src_ff, col_idx);
      end else if (state_ff == S_MIN_SCAN) begin
         rd_en = min_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         weight_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= weight_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         directed_ff   <= 1'b0;
         vcount_ff     <= VERTEX_COUNT_RESET;
         cand_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         for (int r = 0; r < VERTICES; r++) begin
            present_ff[r] <= '0;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_DIRECTED:     directed_ff <= csr_wdata[0];
               CSR_VERTEX_COUNT: vcount_ff   <= csr_wdata;
               default:          ;
            endcase
         end
         if (best_take_in) begin
            found_ff    <= 1'b1;
            best_row_ff <= cand_row_ff;
            best_col_ff <= cand_col_ff;
            best_w_ff   <= rd_data_ff;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  src_ff        <= req_src_idx;
                  dst_ff        <= req_dst_idx;
                  weight_ff     <= req_weight;
                  col_ff        <= '0;
                  row_ff        <= '0;
                  k_ff          <= '0;
                  found_ff      <= 1'b0;
                  cand_valid_ff <= 1'b0;
                  res_status_ff <= ST_OK;
                  res_a_ff      <= '0;
                  res_b_ff      <= '0;
                  res_w_ff      <= '0;
                  state_ff      <= S_EMIT;
                  unique case (req_action)
                     ACT_ADD: begin
                        if (!src_ok_in || !dst_ok_in) begin
                           res_status_ff <= ST_INVALID;
                        end else begin
                           present_ff[req_src_idx][req_dst_idx] <= 1'b1;
                           if (!directed_ff) begin
                              present_ff[req_dst_idx][req_src_idx] <= 1'b1;
                              state_ff <= S_ADD_MIRROR;
                           end
                        end
                     end
                     ACT_REMOVE: begin
                        if (!src_ok_in || !dst_ok_in) begin
                           res_status_ff <= ST_INVALID;
                        end else begin
                           present_ff[req_src_idx][req_dst_idx] <= 1'b0;
                           if (!directed_ff) begin
                              present_ff[req_dst_idx][req_src_idx] <= 1'b0;
                           end
                           if (!present_ff[req_src_idx][req_dst_idx]
                               && (directed_ff || !present_ff[req_dst_idx][req_src_idx])) begin
                              res_status_ff <= ST_NONE;
                           end
                        end
                     end
                     ACT_NEIGHBORS: begin
                        if (!src_ok_in) begin
                           res_status_ff <= ST_INVALID;
                        end else begin
                           state_ff <= S_NBR_SCAN;
                        end
                     end
                     ACT_LOWEST: begin
                        if (n_in == '0) begin
                           res_status_ff <= ST_NONE;
                        end else begin
                           state_ff <= S_MIN_SCAN;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_ADD_MIRROR: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (slot_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_a_ff      <= res_a_ff;
                  rsp_b_ff      <= res_b_ff;
                  rsp_w_ff      <= res_w_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_NBR_SCAN: begin
               if (col_end_in) begin
                  res_status_ff <= ST_NONE;
                  state_ff      <= S_EMIT;
               end else if (nbr_hit_in) begin
                  state_ff <= S_NBR_EMIT;
               end else begin
                  col_ff <= col_ff + NW'(1);
               end
            end
            S_NBR_EMIT: begin
               if (slot_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ST_OK;
                  rsp_a_ff      <= VTX_W'(col_ff);
                  rsp_b_ff      <= '0;
                  rsp_w_ff      <= rd_data_ff;
                  rsp_last_ff   <= !more_in;
                  k_ff          <= k_ff + K_W'(1);
                  col_ff        <= col_ff + NW'(1);
                  state_ff      <= more_in ? S_NBR_SCAN : S_IDLE;
               end
            end
            S_MIN_SCAN: begin
               cand_valid_ff <= min_hit_in;
               cand_row_ff   <= row_idx;
               cand_col_ff   <= col_idx;
               if (col_ff == n_in - NW'(1)) begin
                  col_ff <= '0;
                  if (row_ff == n_in - NW'(1)) begin
                     state_ff <= S_MIN_LAST;
                  end else begin
                     row_ff <= row_ff + NW'(1);
                  end
               end else begin
                  col_ff <= col_ff + NW'(1);
               end
            end
            S_MIN_LAST: begin
               cand_valid_ff <= 1'b0;
               state_ff      <= S_MIN_DONE;
            end
            S_MIN_DONE: begin
               if (found_ff) begin
                  res_status_ff <= ST_OK;
                  res_w_ff      <= best_w_ff;
                  if (!directed_ff && (best_col_ff < best_row_ff)) begin
                     res_a_ff <= VTX_W'(best_col_ff);
                     res_b_ff <= VTX_W'(best_row_ff);
                  end else begin
                     res_a_ff <= VTX_W'(best_row_ff);
                     res_b_ff <= VTX_W'(best_col_ff);
                  end
               end else begin
                  res_status_ff <= ST_NONE;
               end
               state_ff <= S_EMIT;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall       = state_ff != S_IDLE;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_vertex_a    = rsp_a_ff;
   assign rsp_vertex_b    = rsp_b_ff;
   assign rsp_edge_weight = rsp_w_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire

### sim/tb_weighted_edge_table_top.sv
// Self-checking testbench for weighted_edge_table_top: edge adds, removes, neighbor and lowest-edge queries.
`timescale 1ns / 100ps
module tb_weighted_edge_table_top;
   import wet_pkg::*;

   localparam int VERTICES    = 16;
   localparam int HOLD_CYCLES = 400;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 32'sh8000_0000;

   typedef struct {
      logic [ACTION_W-1:0]        action;
      logic [VTX_W-1:0]           src;
      logic [VTX_W-1:0]           dest;
      logic signed [WEIGHT_W-1:0] weight;
   } request_type;

   typedef struct {
      logic [STATUS_W-1:0]        status;
      logic [VTX_W-1:0]           vertex_a;
      logic [VTX_W-1:0]           vertex_b;
      logic signed [WEIGHT_W-1:0] edge_weight;
      logic                       last;
   } response_type;

   // Shadow copy of the edge table; holds the responses still owed by the block.
   class edge_table_ledger;
      bit [VERTICES-1:0]          present [VERTICES];
      logic signed [WEIGHT_W-1:0] weight_of [VERTICES*VERTICES];
      bit                         directed;
      bit [COUNT_W-1:0]           vertex_count;
      response_type               due_responses [$];
      int                         mismatches;

      function new();
         directed     = 1'b0;
         vertex_count = VERTEX_COUNT_RESET;
         mismatches   = 0;
         for (int i = 0; i < VERTICES; i++) present[i] = '0;
         for (int i = 0; i < VERTICES*VERTICES; i++) weight_of[i] = '0;
      endfunction

      function int outstanding();
         return due_responses.size();
      endfunction

      function void set_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_DIRECTED) directed = data[0];
         else vertex_count = data;
      endfunction

      function response_type make_response(input logic [STATUS_W-1:0] status,
                                           input logic [VTX_W-1:0] a,
                                           input logic [VTX_W-1:0] b,
                                           input logic signed [WEIGHT_W-1:0] w,
                                           input logic last);
         response_type r;
         r.status      = status;
         r.vertex_a    = a;
         r.vertex_b    = b;
         r.edge_weight = w;
         r.last        = last;
         return r;
      endfunction

      function void note_action(input request_type rq);
         int n, i, j, bi, bj, hits;
         bit had, found, have_held;
         logic signed [WEIGHT_W-1:0] cw, best_w;
         response_type held;
         n = (vertex_count < VERTICES) ? vertex_count : VERTICES;
         case (rq.action) inside
            ACT_ADD, ACT_REMOVE: begin
               if (rq.src >= n || rq.dest >= n) begin
                  due_responses.push_back(make_response(ST_INVALID, '0, '0, '0, 1'b1));
               end else if (rq.action == ACT_ADD) begin
                  present[rq.src][rq.dest] = 1'b1;
                  weight_of[rq.src*VERTICES + rq.dest] = rq.weight;
                  if (!directed) begin
                     present[rq.dest][rq.src] = 1'b1;
                     weight_of[rq.dest*VERTICES + rq.src] = rq.weight;
                  end
                  due_responses.push_back(make_response(ST_OK, '0, '0, '0, 1'b1));
               end else begin
                  had = present[rq.src][rq.dest];
                  present[rq.src][rq.dest] = 1'b0;
                  if (!directed) begin
                     had = had | present[rq.dest][rq.src];
                     present[rq.dest][rq.src] = 1'b0;
                  end
                  due_responses.push_back(make_response(had ? ST_OK : ST_NONE,
                                                        '0, '0, '0, 1'b1));
               end
            end
            ACT_NEIGHBORS: begin
               if (rq.src >= n) begin
                  due_responses.push_back(make_response(ST_INVALID, '0, '0, '0, 1'b1));
               end else begin
                  hits      = 0;
                  have_held = 1'b0;
                  for (j = 0; j < n && hits < MAX_RESULTS; j++) begin
                     if (present[rq.src][j]) begin
                        if (have_held) due_responses.push_back(held);
                        held = make_response(ST_OK, VTX_W'(j), '0,
                                             weight_of[rq.src*VERTICES + j], 1'b0);
                        have_held = 1'b1;
                        hits++;
                     end
                  end
                  if (!have_held) begin
                     due_responses.push_back(make_response(ST_NONE, '0, '0, '0, 1'b1));
                  end else begin
                     held.last = 1'b1;
                     due_responses.push_back(held);
                  end
               end
            end
            default: begin
               found  = 1'b0;
               bi     = 0;
               bj     = 0;
               best_w = '0;
               for (i = 0; i < n; i++) begin
                  for (j = 0; j < n; j++) begin
                     if (present[i][j]) begin
                        cw = weight_of[i*VERTICES + j];
                        if (!found || cw < best_w) begin
                           found  = 1'b1;
                           bi     = i;
                           bj     = j;
                           best_w = cw;
                        end
                     end
                  end
               end
               if (!found) begin
                  due_responses.push_back(make_response(ST_NONE, '0, '0, '0, 1'b1));
               end else begin
                  if (!directed && bj < bi) begin
                     i  = bi;
                     bi = bj;
                     bj = i;
                  end
                  due_responses.push_back(make_response(ST_OK, VTX_W'(bi), VTX_W'(bj),
                                                        best_w, 1'b1));
               end
            end
         endcase
      endfunction

      task report_mismatch(input string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_response(input logic [STATUS_W-1:0] status,
                          input logic [VTX_W-1:0] vertex_a,
                          input logic [VTX_W-1:0] vertex_b,
                          input logic signed [WEIGHT_W-1:0] edge_weight,
                          input logic last);
         response_type want;
         if (due_responses.size() == 0) begin
            report_mismatch("response transfer with nothing outstanding");
            return;
         end
         want = due_responses.pop_front();
         if (status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status, want.status));
         if (vertex_a !== want.vertex_a)
            report_mismatch($sformatf("vertex_a got %0d want %0d", vertex_a, want.vertex_a));
         if (vertex_b !== want.vertex_b)
            report_mismatch($sformatf("vertex_b got %0d want %0d", vertex_b, want.vertex_b));
         if (edge_weight !== want.edge_weight)
            report_mismatch($sformatf("edge_weight got %0d want %0d",
                                      edge_weight, want.edge_weight));
         if (last !== want.last)
            report_mismatch($sformatf("last got %0d want %0d", last, want.last));
      endtask
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [ACTION_W-1:0]         req_action;
   logic [VTX_W-1:0]            req_src;
   logic [VTX_W-1:0]            req_dest;
   logic signed [WEIGHT_W-1:0]  req_weight;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [STATUS_W-1:0]         rsp_status;
   logic [VTX_W-1:0]            rsp_vertex_a;
   logic [VTX_W-1:0]            rsp_vertex_b;
   logic signed [WEIGHT_W-1:0]  rsp_edge_weight;
   logic                        rsp_last;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;

   edge_table_ledger ledger;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit hold_armed    = 1'b0;
   int hold_left     = 0;

   weighted_edge_table_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_src         (req_src),
      .req_dest        (req_dest),
      .req_weight      (req_weight),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_vertex_a    (rsp_vertex_a),
      .rsp_vertex_b    (rsp_vertex_b),
      .rsp_edge_weight (rsp_edge_weight),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // receiver back-pressure; a long hold-off is counted here once armed
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_armed) begin
         hold_left = HOLD_CYCLES - 1;
         hold_armed <= 1'b0;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         ledger.check_response(rsp_status, rsp_vertex_a, rsp_vertex_b,
                               rsp_edge_weight, rsp_last);
   end

   function automatic logic [VTX_W-1:0] pick_vertex(input int n);
      int v;
      v = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(n - 1);
      return v[VTX_W-1:0];
   endfunction

   function automatic logic signed [WEIGHT_W-1:0] pick_weight();
      int v;
      case ($urandom_range(3)) inside
         0, 1: begin
            v = $urandom_range(8);
            return v - 4;
         end
         2: return $urandom;
         default: begin
            case ($urandom_range(3))
               0: return WEIGHT_MAX;
               1: return WEIGHT_MIN;
               2: return '0;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   function automatic request_type pick_request(input int n);
      request_type rq;
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) rq.action = ACT_ADD;
      else if (roll < 60) rq.action = ACT_REMOVE;
      else if (roll < 80) rq.action = ACT_NEIGHBORS;
      else rq.action = ACT_LOWEST;
      rq.src    = pick_vertex(n);
      rq.dest   = pick_vertex(n);
      rq.weight = pick_weight();
      return rq;
   endfunction

   // entered and left at a falling edge; valid stays high across back-to-back transfers
   task automatic send_request(input request_type rq);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= rq.action;
      req_src    <= rq.src;
      req_dest   <= rq.dest;
      req_weight <= rq.weight;
      do @(posedge clock); while (req_stall);
      ledger.note_action(rq);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [ACTION_W-1:0] action,
                              input logic [VTX_W-1:0] src,
                              input logic [VTX_W-1:0] dest,
                              input logic signed [WEIGHT_W-1:0] weight);
      request_type rq;
      rq.action = action;
      rq.src    = src;
      rq.dest   = dest;
      rq.weight = weight;
      send_request(rq);
   endtask

   task automatic wait_quiet(input int settle);
      while (ledger.outstanding() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic program_registers(input bit directed, input logic [CSR_DATA_W-1:0] count);
      for (int r = 0; r < 2; r++) begin
         csr_valid <= 1'b1;
         csr_index <= (r == 0) ? CSR_DIRECTED : CSR_VERTEX_COUNT;
         csr_wdata <= (r == 0) ? CSR_DATA_W'(directed) : count;
         do @(posedge clock); while (!csr_ready);
         ledger.set_register((r == 0) ? CSR_DIRECTED : CSR_VERTEX_COUNT,
                             (r == 0) ? CSR_DATA_W'(directed) : count);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      send_idle_pct = 0;
      send_fields(ACT_LOWEST, 4'd0, 4'd0, '0);
      send_fields(ACT_NEIGHBORS, 4'd0, 4'd0, '0);
      send_fields(ACT_REMOVE, 4'd3, 4'd4, '0);
      send_fields(ACT_ADD, 4'd15, 4'd0, WEIGHT_MAX);
      send_fields(ACT_LOWEST, 4'd9, 4'd9, '0);
      send_fields(ACT_ADD, 4'd3, 4'd3, WEIGHT_MIN);
      send_fields(ACT_ADD, 4'd5, 4'd2, -32'sd7);
      send_fields(ACT_ADD, 4'd0, 4'd1, '0);
      send_fields(ACT_ADD, 4'd0, 4'd2, '0);
      send_fields(ACT_NEIGHBORS, 4'd0, 4'd15, 32'sd55);
      send_fields(ACT_LOWEST, 4'd0, 4'd0, '0);
      send_fields(ACT_REMOVE, 4'd3, 4'd3, '0);
      send_fields(ACT_LOWEST, 4'd0, 4'd0, '0);
      send_fields(ACT_REMOVE, 4'd2, 4'd5, 32'sd12345);
      send_fields(ACT_LOWEST, 4'd0, 4'd0, '0);
      send_fields(ACT_ADD, 4'd15, 4'd15, '1);
      req_valid <= 1'b0;
      // directed, four vertices: out-of-range indexes and hidden edges
      wait_quiet(8);
      program_registers(1'b1, 5'd4);
      send_fields(ACT_ADD, 4'd7, 4'd1, 32'sd5);
      send_fields(ACT_REMOVE, 4'd1, 4'd9, '0);
      send_fields(ACT_NEIGHBORS, 4'd12, 4'd0, '0);
      send_fields(ACT_ADD, 4'd2, 4'd1, -32'sd3);
      send_fields(ACT_NEIGHBORS, 4'd1, 4'd0, '0);
      send_fields(ACT_REMOVE, 4'd1, 4'd2, '0);
      send_fields(ACT_LOWEST, 4'd0, 4'd0, '0);
      req_valid <= 1'b0;
   endtask

   task automatic run_phase(input bit directed, input logic [CSR_DATA_W-1:0] count,
                            input int send_pct, input int rsp_pct, input int items,
                            input bit squeeze, input bit pause_midway);
      int n;
      n = (count < VERTICES) ? count : VERTICES;
      wait_quiet(8);
      program_registers(directed, count);
      send_idle_pct = send_pct;
      stall_pct <= rsp_pct;
      if (squeeze) hold_armed <= 1'b1;
      for (int i = 0; i < items; i++) begin
         if (pause_midway && i == items / 2) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (ledger.outstanding() != 0);
         end
         send_request(pick_request(n));
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      ledger     = new();
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_action = ACT_ADD;
      req_src    = '0;
      req_dest   = '0;
      req_weight = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_DIRECTED;
      csr_wdata  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      run_phase(1'b0, 5'd16, 0, 0, 34, 1'b0, 1'b0);
      run_phase(1'b1, 5'd16, 88, 0, 34, 1'b0, 1'b0);
      run_phase(1'b0, 5'd5, 0, 88, 34, 1'b0, 1'b0);
      run_phase(1'b1, 5'd1, 30, 30, 30, 1'b0, 1'b0);
      run_phase(1'b0, 5'd10, 0, 0, 40, 1'b1, 1'b0);
      run_phase(1'b1, 5'd3, 88, 0, 34, 1'b0, 1'b1);
      run_phase(1'b0, 5'd15, 0, 88, 34, 1'b0, 1'b0);
      run_phase(1'b1, 5'd16, 30, 30, 30, 1'b0, 1'b1);

      wait_quiet(300);
      if (ledger.mismatches == 0 && ledger.outstanding() == 0)
         $display("tb_weighted_edge_table_top passed");
      else
         $display("tb_weighted_edge_table_top failed");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("tb_weighted_edge_table_top failed");
      $finish;
   end

endmodule

### weighted_edge_table_top.f
rtl/wet_pkg.sv
rtl/weighted_edge_table_top.sv
sim/tb_weighted_edge_table_top.sv
